// ----- hdl/sacl_pkg.sv -----
package sacl_pkg;
  localparam int MAX_SETS_DEF = 256;
  localparam int MAX_WAYS_DEF = 8;
  localparam int ADDR_WIDTH_DEF = 64;
  localparam logic [1:0] ACT_LS = 2'd0;
  localparam logic [1:0] ACT_MOD = 2'd1;
  localparam logic [3:0] RST_SET_BITS = 4'd4;
  localparam logic [3:0] RST_WAYS = 4'd1;
  localparam logic [5:0] RST_BLOCK_BITS = 6'd4;
  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_WAYS = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  typedef struct packed {
    logic [3:0] set_bits;
    logic [3:0] ways_in_use;
    logic [5:0] block_bits;
  } cfg_t;

  typedef struct packed {
    logic        hit;
    logic        miss;
    logic        evicted;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
    logic        last;
  } res_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction
endpackage

// ----- hdl/sacl_if.sv -----
interface sacl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] address;
  modport source (output valid, action, address, input ready);
  modport sink (input valid, action, address, output ready);
endinterface

interface sacl_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        miss;
  logic        evicted;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] eviction_total;
  logic        last;
  modport source (output valid, hit, miss, evicted, hit_total, miss_total, eviction_total,
                  last, input ready);
  modport sink (input valid, hit, miss, evicted, hit_total, miss_total, eviction_total,
                last, output ready);
endinterface

// ----- hdl/sacl_cfg.sv -----
module sacl_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sacl_pkg::cfg_t    cfg
);
  sacl_pkg::cfg_t cfg_r;
  logic [1:0] idx;
  assign idx = paddr[3:2];
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_bits <= sacl_pkg::RST_SET_BITS;
      cfg_r.ways_in_use <= sacl_pkg::RST_WAYS;
      cfg_r.block_bits <= sacl_pkg::RST_BLOCK_BITS;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        sacl_pkg::REG_SET_BITS: cfg_r.set_bits <= pwdata[3:0];
        sacl_pkg::REG_WAYS: cfg_r.ways_in_use <= pwdata[3:0];
        sacl_pkg::REG_BLOCK_BITS: cfg_r.block_bits <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sacl_pkg::REG_SET_BITS: prdata = {28'd0, cfg_r.set_bits};
      sacl_pkg::REG_WAYS: prdata = {28'd0, cfg_r.ways_in_use};
      sacl_pkg::REG_BLOCK_BITS: prdata = {26'd0, cfg_r.block_bits};
      default: prdata = '0;
    endcase
  end
endmodule

// ----- hdl/sacl_core.sv -----
module sacl_core #(
  parameter int MAX_SETS = sacl_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sacl_pkg::cfg_t cfg,
  sacl_in_if.sink        in_ch,
  sacl_out_if.source     out_ch
);
  localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CW = $clog2(MAX_WAYS + 1);
  localparam int TW = ADDR_WIDTH;
  localparam logic [WW-1:0] RMAX = WW'(MAX_WAYS - 1);

  typedef struct packed {
    logic [MAX_WAYS-1:0]         valid;
    logic [MAX_WAYS-1:0][WW-1:0] rank;
    logic [MAX_WAYS-1:0][TW-1:0] tags;
  } set_t;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_UPD, S_OUT} st_t;

  set_t mem [MAX_SETS];
  logic [MAX_SETS-1:0] init_r;
  set_t rd_r;
  logic rd_init_r;
  st_t st_r;
  logic two_r;
  logic [SW-1:0] idx_r;
  logic [TW-1:0] tag_r;
  logic [31:0] hc_r, mc_r, ec_r;
  sacl_pkg::res_t res_r;
  logic byp_r;
  set_t wb_r;

  logic [6:0] sh;
  logic [TW-1:0] a_c, tag_c, ib;
  logic [SW-1:0] idx_c;
  logic [CW-1:0] ways;
  assign a_c = TW'(in_ch.address);
  assign sh = {3'd0, cfg.set_bits} + {1'b0, cfg.block_bits};
  assign ib = ({1'b0, cfg.block_bits} >= 7'(TW)) ? '0 : a_c >> cfg.block_bits;
  assign tag_c = (sh >= 7'(TW)) ? '0 : a_c >> sh;
  always_comb begin
    logic [TW-1:0] m;
    m = (32'(cfg.set_bits) >= TW) ? '1 : ~({TW{1'b1}} << cfg.set_bits);
    idx_c = SW'((ib & m) % MAX_SETS);
  end
  always_comb begin
    if (cfg.ways_in_use == 4'd0) ways = CW'(1);
    else if (32'(cfg.ways_in_use) > MAX_WAYS) ways = CW'(MAX_WAYS);
    else ways = CW'(cfg.ways_in_use);
  end

  set_t cur, nxt;
  logic hit_c, emp_c, vic_c, ev_c;
  logic [WW-1:0] hw, ew, vw, tw, old, mx;
  always_comb begin
    cur = byp_r ? wb_r : rd_r;
    if (!rd_init_r && !byp_r) begin
      cur.valid = '0;
      cur.rank = '0;
    end
    hit_c = 1'b0; emp_c = 1'b0; vic_c = 1'b0;
    hw = '0; ew = '0; vw = '0; mx = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < 32'(ways)) begin
        if (cur.valid[w] && cur.tags[w] == tag_r) begin hit_c = 1'b1; hw = WW'(w); end
        if (!cur.valid[w]) begin emp_c = 1'b1; ew = WW'(w); end
      end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < 32'(ways) && cur.valid[w] && (!vic_c || cur.rank[w] > mx)) begin
        vic_c = 1'b1; vw = WW'(w); mx = cur.rank[w];
      end
    end
    ev_c = !hit_c && !emp_c;
    tw = hit_c ? hw : (emp_c ? ew : vw);
    old = cur.rank[tw];
    nxt = cur;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < 32'(ways) && WW'(w) != tw && cur.valid[w] && cur.rank[w] != RMAX &&
          (!hit_c && emp_c || cur.rank[w] < old))
        nxt.rank[w] = cur.rank[w] + WW'(1);
    end
    nxt.rank[tw] = '0;
    nxt.valid[tw] = 1'b1;
    nxt.tags[tw] = tag_r;
  end

  always_ff @(posedge clk) begin
    if (st_r == S_READ) begin
      rd_r <= mem[idx_r];
      rd_init_r <= init_r[idx_r];
    end
    if (st_r == S_UPD) begin
      mem[idx_r] <= nxt;
      wb_r <= nxt;
      res_r.hit <= hit_c;
      res_r.miss <= !hit_c;
      res_r.evicted <= ev_c;
      res_r.hit_total <= hit_c ? sacl_pkg::sat_inc(hc_r) : hc_r;
      res_r.miss_total <= hit_c ? mc_r : sacl_pkg::sat_inc(mc_r);
      res_r.eviction_total <= ev_c ? sacl_pkg::sat_inc(ec_r) : ec_r;
      res_r.last <= !two_r;
    end
    if (st_r == S_IDLE) begin
      idx_r <= idx_c;
      tag_r <= tag_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      init_r <= '0;
      hc_r <= '0; mc_r <= '0; ec_r <= '0;
      two_r <= 1'b0;
      byp_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_ch.valid && in_ch.ready &&
                    (in_ch.action == sacl_pkg::ACT_LS || in_ch.action == sacl_pkg::ACT_MOD)) begin
          two_r <= (in_ch.action == sacl_pkg::ACT_MOD);
          st_r <= S_READ;
          byp_r <= 1'b0;
        end
        S_READ: st_r <= S_UPD;
        S_UPD: begin
          init_r[idx_r] <= 1'b1;
          if (hit_c) hc_r <= sacl_pkg::sat_inc(hc_r);
          else mc_r <= sacl_pkg::sat_inc(mc_r);
          if (ev_c) ec_r <= sacl_pkg::sat_inc(ec_r);
          st_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          if (two_r) begin
            two_r <= 1'b0;
            byp_r <= 1'b1;
            st_r <= S_UPD;
          end else st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.hit = res_r.hit;
  assign out_ch.miss = res_r.miss;
  assign out_ch.evicted = res_r.evicted;
  assign out_ch.hit_total = res_r.hit_total;
  assign out_ch.miss_total = res_r.miss_total;
  assign out_ch.eviction_total = res_r.eviction_total;
  assign out_ch.last = res_r.last;
endmodule

// ----- hdl/set_assoc_cache_lru_sim.sv -----
// channel | dir | payload
// in_     | in  | action[1:0], address[63:0]
// out_    | out | hit, miss, evicted, hit/miss/eviction_total[31:0], last
// cfg_    | in  | APB, regs set_bits @0x0, ways_in_use @0x4, block_bits @0x8
// A load/store goes through read, update and output states to its result;
// a modify redoes update and output once its first result is taken.
// Set state lives in one memory row per set, read then written back.
// Reset: per-set init bits clear at once, no clearing pass.
// Input is held off while a result waits on out_ready.
module set_assoc_cache_lru_sim #(
  parameter int MAX_SETS = sacl_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sacl_in_if.sink     in_ch,
  sacl_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  sacl_pkg::cfg_t cfg;
  sacl_cfg u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata), .pready(cfg_pready),
    .cfg(cfg)
  );
  sacl_core #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_WIDTH(ADDR_WIDTH)) u_core (
    .clk, .rst_n, .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule

// ----- hdl/sacl_chk.sv -----
module sacl_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit,
  input logic out_miss,
  input logic [31:0] out_hit_total
);
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit ^ out_miss)) else $error("hit/miss not exclusive");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hcnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit_total)) else $error("count moved");
endmodule

bind set_assoc_cache_lru_sim sacl_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_hit(out_ch.hit),
  .out_miss(out_ch.miss), .out_hit_total(out_ch.hit_total)
);

// ----- tb/set_assoc_cache_lru_sim_tb.sv -----
module set_assoc_cache_lru_sim_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  localparam int NSETS = MAX_SETS_DEF;
  localparam int NWAYS = MAX_WAYS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam logic [1:0] ACT_IFETCH = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sacl_in_if  in_if ();
  sacl_out_if out_if ();

  set_assoc_cache_lru_sim dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // cache state mirror
  logic [63:0] line_tag [NSETS*NWAYS];
  bit          line_ok  [NSETS*NWAYS];
  int          line_age [NSETS*NWAYS];
  logic [31:0] hits_seen, misses_seen, evicts_seen;
  cfg_t        cur_cfg;

  res_t        pending_res[$];
  logic [63:0] addr_pool[$];
  int          mismatches, items_sent, results_seen, idle_cycles;
  bit          no_idle;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void age_ways(int base, int ways, int touched, int old);
    for (int w = 0; w < ways; w++) begin
      if (w != touched && line_ok[base+w] && line_age[base+w] < old &&
          line_age[base+w] < NWAYS - 1)
        line_age[base+w]++;
    end
    line_age[base+touched] = 0;
  endfunction

  function automatic void predict_access(logic [63:0] addr, bit is_last);
    int shift, ways, base, empty_w, victim_w, max_age;
    bit got_empty, got_victim, found;
    logic [63:0] tag, idx;
    res_t r;
    shift = cur_cfg.set_bits + cur_cfg.block_bits;
    tag = (shift >= 64) ? 64'd0 : addr >> shift;
    idx = (cur_cfg.block_bits >= 64) ? 64'd0 : addr >> cur_cfg.block_bits;
    idx &= (64'd1 << cur_cfg.set_bits) - 64'd1;
    idx = idx % NSETS;
    ways = (cur_cfg.ways_in_use == 0) ? 1 :
           (cur_cfg.ways_in_use > NWAYS) ? NWAYS : cur_cfg.ways_in_use;
    base = int'(idx) * NWAYS;
    got_empty = 0; got_victim = 0; found = 0;
    empty_w = 0; victim_w = 0; max_age = 0;
    r = '0;
    for (int w = 0; w < ways; w++) begin
      if (line_ok[base+w] && line_tag[base+w] == tag) begin
        age_ways(base, ways, w, line_age[base+w]);
        found = 1;
        break;
      end
      if (!line_ok[base+w]) begin
        if (!got_empty) begin
          got_empty = 1;
          empty_w = w;
        end
      end else if (!got_victim || line_age[base+w] > max_age) begin
        got_victim = 1;
        victim_w = w;
        max_age = line_age[base+w];
      end
    end
    if (found) begin
      hits_seen = bump(hits_seen);
    end else begin
      misses_seen = bump(misses_seen);
      if (got_empty) begin
        line_tag[base+empty_w] = tag;
        line_ok[base+empty_w] = 1;
        age_ways(base, ways, empty_w, NWAYS);
      end else begin
        evicts_seen = bump(evicts_seen);
        r.evicted = 1;
        line_tag[base+victim_w] = tag;
        age_ways(base, ways, victim_w, line_age[base+victim_w]);
      end
    end
    r.hit = found;
    r.miss = !found;
    r.hit_total = hits_seen;
    r.miss_total = misses_seen;
    r.eviction_total = evicts_seen;
    r.last = is_last;
    pending_res.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_idle || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls, checking of every transfer
  int ready_hold;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      ready_hold <= 0;
    end else if (no_idle) begin
      out_if.ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold == 0) begin
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) begin
        out_if.ready <= 1'b1;
        ready_hold <= $urandom_range(0, 8);
      end else if (r < 18) begin
        out_if.ready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_if.ready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      res_t got, want;
      got = '{out_if.hit, out_if.miss, out_if.evicted, out_if.hit_total,
              out_if.miss_total, out_if.eviction_total, out_if.last};
      results_seen++;
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] act, logic [63:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.address <= addr;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    if (act == ACT_LS) predict_access(addr, 1);
    else if (act == ACT_MOD) begin
      predict_access(addr, 0);
      predict_access(addr, 1);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] reg_idx, int value);
    drain();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (reg_idx)
      REG_SET_BITS: cur_cfg.set_bits = value[3:0];
      REG_WAYS: cur_cfg.ways_in_use = value[3:0];
      REG_BLOCK_BITS: cur_cfg.block_bits = value[5:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int sb, int ways, int bb);
    cfg_write(REG_SET_BITS, sb);
    cfg_write(REG_WAYS, ways);
    cfg_write(REG_BLOCK_BITS, bb);
  endtask

  // addresses that land on few sets with varied tags, so hits and evictions mix
  task automatic fill_pool(int n);
    logic [63:0] a, idx_mask;
    int sh;
    addr_pool.delete();
    sh = cur_cfg.set_bits + cur_cfg.block_bits;
    idx_mask = (sh >= 64) ? ~64'd0 : ((64'd1 << sh) - 64'd1);
    for (int k = 0; k < n; k++) begin
      a = {$urandom, $urandom};
      if (k > 0 && (k % 2) == 1)
        a = (a & ~idx_mask) | (addr_pool[0] & idx_mask);
      addr_pool.push_back(a);
    end
  endtask

  task automatic run_random(int n, int pool_n);
    logic [63:0] a, off_mask;
    int r;
    logic [1:0] act;
    fill_pool(pool_n);
    off_mask = (cur_cfg.block_bits >= 64) ? ~64'd0 :
               ((64'd1 << cur_cfg.block_bits) - 64'd1);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      act = (r < 6) ? ACT_LS : (r < 9) ? ACT_MOD :
            ($urandom_range(0, 1) ? ACT_IFETCH : ACT_UNUSED);
      if ($urandom_range(0, 99) < 85)
        a = addr_pool[$urandom_range(0, pool_n - 1)] ^ ({$urandom, $urandom} & off_mask);
      else
        a = {$urandom, $urandom};
      send_item(act, a);
      if (act == ACT_IFETCH || act == ACT_UNUSED) k--;
    end
  endtask

  task automatic test_directed();
    set_geometry(1, 2, 0);
    send_item(ACT_LS, 64'd0);
    send_item(ACT_LS, 64'd0);
    send_item(ACT_LS, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_MOD, 64'h4);
    send_item(ACT_LS, 64'h8);
    send_item(ACT_LS, 64'h0);
    send_item(ACT_LS, 64'hC);
    send_item(ACT_IFETCH, 64'h0);
    send_item(ACT_UNUSED, 64'h0);
    send_item(ACT_MOD, 64'h10);
    send_item(ACT_LS, 64'h4);
    send_item(ACT_LS, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(ACT_MOD, 64'h8000_0000_0000_0000);
    send_item(ACT_LS, 64'h1);
    set_geometry(15, 0, 63);
    send_item(ACT_LS, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_LS, 64'h0);
    send_item(ACT_MOD, 64'h8000_0000_0000_0000);
    set_geometry(8, 15, 32);
    send_item(ACT_LS, 64'h1234_5678_0000_0000);
    send_item(ACT_LS, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_MOD, 64'h0);
  endtask

  task automatic test_geometry_sweep();
    int geo [10][3] = '{'{0, 1, 0}, '{1, 2, 4}, '{2, 4, 6}, '{3, 8, 5}, '{8, 8, 32},
                        '{15, 15, 63}, '{4, 0, 4}, '{0, 8, 0}, '{2, 3, 1}, '{5, 8, 10}};
    for (int g = 0; g < 10; g++) begin
      set_geometry(geo[g][0], geo[g][1], geo[g][2]);
      run_random(110, 4 + 2 * geo[g][1]);
    end
  endtask

  task automatic test_drained_restart();
    set_geometry(2, 4, 3);
    run_random(40, 10);
    drain();
    run_random(40, 10);
  endtask

  task automatic test_back_to_back();
    set_geometry(1, 8, 2);
    no_idle = 1;
    run_random(80, 14);
    no_idle = 0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.action <= ACT_LS;
    in_if.address <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    no_idle = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    hits_seen = 0;
    misses_seen = 0;
    evicts_seen = 0;
    cur_cfg = '{RST_SET_BITS, RST_WAYS, RST_BLOCK_BITS};
    for (int i = 0; i < NSETS * NWAYS; i++) begin
      line_ok[i] = 0;
      line_age[i] = 0;
      line_tag[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_geometry_sweep();
    test_drained_restart();
    test_back_to_back();

    drain();
    mismatches += pending_res.size();
    $display("%0d items sent, %0d results checked over 15 cache geometries", items_sent,
             results_seen);
    $display("totals: %0d hits, %0d misses, %0d evictions", hits_seen, misses_seen,
             evicts_seen);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
